### rtl/trm_pkg.sv
// Shared types and constants for the tiled row append merge block.
// Depends on nothing; trm_decode and the top level import it.
package trm_pkg;

   localparam int TILE_WORDS = 512;
   localparam int TILE_ROWS  = 32;
   localparam int WORD_W     = 32;
   localparam int OFF_W      = 9;
   localparam int TILE_W     = 15;
   localparam int START_W    = 20;
   localparam int COUNT_W    = 6;
   localparam int ROW_W      = 5;
   localparam int ABS_W      = TILE_W + ROW_W;
   localparam int PADDR_W    = 3;
   localparam int PDATA_W    = 32;

   // Item commands.
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_MERGE = 1'b1;

   // Register byte addresses.
   localparam logic [PADDR_W-1:0] REG_START_ROW = 3'd0;
   localparam logic [PADDR_W-1:0] REG_ROW_COUNT = 3'd4;

   typedef enum logic [1:0] {
      SRC_KEPT  = 2'd0,
      SRC_DELTA = 2'd1,
      SRC_ZERO  = 2'd2
   } src_type;

   typedef struct packed {
      src_type          src;
      logic [OFF_W-1:0] rd_addr;
   } dec_type;

endpackage

### rtl/trm_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module trm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/trm_decode.sv
// Offset decode and row classification for one merge word.
// Depends on trm_pkg.
module trm_decode
   import trm_pkg::*;
(
   input  logic [OFF_W-1:0]   word_offset,
   input  logic [TILE_W-1:0]  tile_index,
   input  logic [START_W-1:0] start_row,
   input  logic [COUNT_W-1:0] row_count,
   output dec_type            dec
);

   logic [ROW_W-1:0]   row;
   logic [ABS_W-1:0]   abs_row;
   logic [START_W-1:0] added;
   logic               kept;
   logic               appended;

   always_comb begin
      // Bit 8 picks the row half, bits 6..3 the row inside the face.
      row      = {word_offset[8], word_offset[6:3]};
      abs_row  = {tile_index, row};
      kept     = abs_row < start_row;
      added    = abs_row - start_row;
      // Appended rows past the one delta tile are clipped to zero fill.
      appended = (added[START_W-1:ROW_W] == '0) &&
                 ({1'b0, added[ROW_W-1:0]} < row_count);
      if (kept) begin
         dec.src = SRC_KEPT;
      end else if (appended) begin
         dec.src = SRC_DELTA;
      end else begin
         dec.src = SRC_ZERO;
      end
      dec.rd_addr = {added[4], word_offset[7], added[3:0], word_offset[2:0]};
   end

endmodule

### rtl/tiled_row_append_merge_top.sv
// A merge word passes the input stage, the store read stage and the result register before it shows on rsp_valid.
// Throughput: one word per cycle while rsp_stall does not hold the stages; a load word gives no result.
// The delta store read sets the middle stage; the result register parts the output.
// Synchronous reset clears the stage valids and both configuration registers to zero.
// The delta store is not cleared; an entry reads as written once loaded.
// Top level; depends on trm_pkg, trm_decode and trm_ram.
module tiled_row_append_merge_top
   import trm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_cmd,
   input  logic [OFF_W-1:0]    req_word_offset,
   input  logic [TILE_W-1:0]   req_tile_index,
   input  logic [WORD_W-1:0]   req_data_word,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [WORD_W-1:0]   rsp_merged_word,
   output logic [OFF_W-1:0]    rsp_out_offset,
   output logic [1:0]          rsp_row_source,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [PADDR_W-1:0]  paddr,
   input  logic [PDATA_W-1:0]  pwdata,
   output logic [PDATA_W-1:0]  prdata,
   output logic                pready
);

   localparam int AW = $clog2(TILE_WORDS);

   // Configuration registers.
   logic [START_W-1:0] start_ff, start_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               cfg_wr;

   // Input stage.
   logic               s1_vld_ff, s1_vld_in;
   logic               s1_cmd_ff;
   logic [OFF_W-1:0]   s1_off_ff;
   logic [TILE_W-1:0]  s1_tile_ff;
   logic [WORD_W-1:0]  s1_data_ff;

   // Store read stage.
   logic               s2_vld_ff, s2_vld_in;
   src_type            s2_src_ff;
   logic [OFF_W-1:0]   s2_off_ff;
   logic [WORD_W-1:0]  s2_data_ff;

   // Result register.
   logic               out_vld_ff, out_vld_in;
   logic [WORD_W-1:0]  out_word_ff, out_word_in;
   logic [OFF_W-1:0]   out_off_ff;
   logic [1:0]         out_src_ff;

   logic               accept;
   logic               s1_go, s2_go, s2_free, out_free;
   logic               ram_we, ram_re;
   logic [WORD_W-1:0]  ram_q;
   dec_type            dec;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;

   always_comb begin
      start_in = start_ff;
      count_in = count_ff;
      if (cfg_wr) begin
         if (paddr[2] == REG_ROW_COUNT[2]) begin
            count_in = pwdata[COUNT_W-1:0];
         end else begin
            start_in = pwdata[START_W-1:0];
         end
      end
      if (paddr[2] == REG_ROW_COUNT[2]) begin
         prdata = {{(PDATA_W-COUNT_W){1'b0}}, count_ff};
      end else begin
         prdata = {{(PDATA_W-START_W){1'b0}}, start_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         count_ff <= '0;
      end else begin
         start_ff <= start_in;
         count_ff <= count_in;
      end
   end

   // Stage flow. Load words retire from the input stage by writing the store.
   always_comb begin
      out_free  = !out_vld_ff || !rsp_stall;
      s2_go     = s2_vld_ff && out_free;
      s2_free   = !s2_vld_ff || out_free;
      s1_go     = s1_vld_ff && ((s1_cmd_ff == CMD_LOAD) || s2_free);
      req_stall = s1_vld_ff && !s1_go;
      accept    = req_valid && !req_stall;
      ram_we    = s1_vld_ff && (s1_cmd_ff == CMD_LOAD);
      ram_re    = s1_go && (s1_cmd_ff == CMD_MERGE);

      s1_vld_in  = accept || (s1_vld_ff && !s1_go);
      s2_vld_in  = ram_re || (s2_vld_ff && !s2_go);
      out_vld_in = s2_go || (out_vld_ff && rsp_stall);

      case (s2_src_ff)
         SRC_KEPT:  out_word_in = s2_data_ff;
         SRC_DELTA: out_word_in = ram_q;
         default:   out_word_in = '0;
      endcase
   end

   trm_decode u_decode (
      .word_offset (s1_off_ff),
      .tile_index  (s1_tile_ff),
      .start_row   (start_ff),
      .row_count   (count_ff),
      .dec         (dec)
   );

   trm_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TILE_WORDS)
   ) u_delta_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (s1_off_ff[AW-1:0]),
      .wdata (s1_data_ff),
      .re    (ram_re),
      .raddr (dec.rd_addr[AW-1:0]),
      .rdata (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff  <= req_cmd;
         s1_off_ff  <= req_word_offset;
         s1_tile_ff <= req_tile_index;
         s1_data_ff <= req_data_word;
      end
      if (ram_re) begin
         s2_src_ff  <= dec.src;
         s2_off_ff  <= s1_off_ff;
         s2_data_ff <= s1_data_ff;
      end
      if (s2_go) begin
         out_word_ff <= out_word_in;
         out_off_ff  <= s2_off_ff;
         out_src_ff  <= s2_src_ff;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_merged_word = out_word_ff;
   assign rsp_out_offset  = out_off_ff;
   assign rsp_row_source  = out_src_ff;

`ifndef NO_ASSERTIONS
   a_store_one_port: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("delta store written and read in the same cycle");

   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_vld_ff)
      else $error("input stalled with an empty input stage");

   a_zero_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_row_source == SRC_ZERO)) |-> (rsp_merged_word == '0))
      else $error("zero fill row carries a nonzero word");

   a_kept_word: assert property (@(posedge clock) disable iff (reset)
      (s2_go && (s2_src_ff == SRC_KEPT)) |=> (rsp_merged_word == $past(s2_data_ff)))
      else $error("kept row lost its old word");
`endif

endmodule
